// ===== design/lzc_pkg.sv =====
// ----------------------------------------------------------------------------
// lzc_pkg
// Shared constants, register codes, stage flags and helpers for the
// Laplacian zero-crossing edge overlay.
// ----------------------------------------------------------------------------
package lzc_pkg;

   // default frame limits
   localparam int LZC_MAX_WIDTH  = 2048;
   localparam int LZC_MAX_HEIGHT = 2048;
   localparam int MIN_SIZE       = 5;

   // configuration port
   localparam int CSR_DATA_W = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic [11:0] FRAME_WIDTH_RST    = 12'd1280;
   localparam logic [11:0] FRAME_HEIGHT_RST   = 12'd960;
   localparam logic [6:0]  EDGE_THRESHOLD_RST = 7'd7;
   localparam logic [7:0]  LAPLACIAN_BIAS_RST = 8'd127;

   // line buffer rings and window sizes
   localparam int GRAY_BANKS  = 3;
   localparam int LAP_BANKS   = 5;
   localparam int COLOR_BANKS = 4;
   localparam int GRAY_TAPS   = 3;
   localparam int LAP_TAPS    = 5;

   // round(sum/3) = floor((sum+1) * 683 / 2048) for sums up to 2046
   localparam int GRAY_RECIP = 683;
   localparam int GRAY_SHIFT = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2,
      CSR_LAPLACIAN_BIAS = 2'd3
   } csr_index_type;

   // per-request control that travels with it down the pipeline
   typedef struct packed {
      logic lap_wr;    // Laplacian position lies inside the frame
      logic lap_zero;  // Laplacian position on the outermost ring
      logic out_en;    // request produces a result
      logic inner;     // result pixel at least two away from every edge
      logic last;      // result is the final pixel of the frame
   } stage_flags_type;

   // gray level of an RGB pixel, rounded to nearest
   function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [9:0]  sum;
      logic [19:0] prod;
      sum  = 10'(r) + 10'(g) + 10'(b) + 10'd1;
      prod = 20'(sum) * 20'(GRAY_RECIP);
      return prod[GRAY_SHIFT +: 8];
   endfunction

   // (bank + k) mod GRAY_BANKS
   function automatic logic [1:0] gray_bank_add(input logic [1:0] bank, input logic [1:0] k);
      logic [2:0] s;
      s = 3'(bank) + 3'(k);
      if (s >= 3'(GRAY_BANKS)) begin
         s = s - 3'(GRAY_BANKS);
      end
      return s[1:0];
   endfunction

   // (bank - k) mod LAP_BANKS
   function automatic logic [2:0] lap_bank_sub(input logic [2:0] bank, input logic [2:0] k);
      logic [3:0] s;
      s = 4'(bank) + 4'(LAP_BANKS) - 4'(k);
      if (s >= 4'(LAP_BANKS)) begin
         s = s - 4'(LAP_BANKS);
      end
      return s[2:0];
   endfunction

endpackage

// ===== design/lzc_ram.sv =====
// ----------------------------------------------------------------------------
// lzc_ram
// Simple dual-port line buffer: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module lzc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lzc_front.sv =====
// ----------------------------------------------------------------------------
// lzc_front
// Raster counters, gray conversion, gray and color line buffers, and the
// input stage register.
// ----------------------------------------------------------------------------
module lzc_front
   import lzc_pkg::*;
#(
   parameter int MAX_WIDTH  = LZC_MAX_WIDTH,
   parameter int MAX_HEIGHT = LZC_MAX_HEIGHT,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            restart,
   input  logic                            req_take,
   input  logic                            req_mode,
   input  logic [7:0]                      req_red,
   input  logic [7:0]                      req_green,
   input  logic [7:0]                      req_blue,
   input  logic [WW-1:0]                   eff_w,
   input  logic [HW-1:0]                   eff_h,
   input  logic                            a_move,
   output logic                            a_valid,
   output stage_flags_type                 a_flags,
   output logic [2:0]                      a_lap_bank,
   output logic [CW-1:0]                   a_lap_col,
   output logic [GRAY_TAPS-1:0][7:0]       gray_col,
   output logic [23:0]                     color_rd,
   output logic                            lap_rd_en,
   output logic [CW-1:0]                   lap_rd_col
);

   localparam int RW  = $clog2(MAX_HEIGHT + 8);
   localparam int CBW = $clog2(COLOR_BANKS);

   logic [CW-1:0] icol_ff, icol_in;
   logic [RW-1:0] irow_ff, irow_in;
   logic [1:0]    gptr_ff, gptr_in;
   logic [2:0]    lptr_ff, lptr_in;

   logic            a_valid_ff, a_valid_in;
   stage_flags_type a_flags_ff;
   logic [2:0]      a_lap_bank_ff;
   logic [CW-1:0]   a_lap_col_ff;
   logic [7:0]      a_gray_ff;
   logic [1:0]      a_gptr_ff;

   logic [RW-1:0]   h_ext;
   logic [CW:0]     w_ext;
   logic [CW:0]     icol_ext;
   logic            intake, proc, gray_wr, col_last;
   logic            lstart, ostart;
   logic [RW-1:0]   lrow, orow;
   logic [CW-1:0]   lcol, ocol;
   logic [CW:0]     ocol_ext;
   logic [RW:0]     orow_p2;
   logic [2:0]      lap_bank;
   stage_flags_type flags;
   logic [7:0]      gray_new;
   logic [7:0]      gray_rd [GRAY_BANKS];

   assign h_ext    = RW'(eff_h);
   assign w_ext    = (CW + 1)'(eff_w);
   assign icol_ext = {1'b0, icol_ff};

   // classify the request against the current raster position
   assign intake  = irow_ff < h_ext;
   assign proc    = req_take && !(intake && req_mode);
   assign gray_wr = proc && intake;
   assign col_last = icol_ext == w_ext - (CW + 1)'(1);

   // Laplacian position trails the input by one row and one pixel
   always_comb begin
      lstart = (irow_ff >= RW'(2)) || (irow_ff == RW'(1) && icol_ff != '0);
      if (icol_ff != '0) begin
         lrow     = irow_ff - RW'(1);
         lcol     = icol_ff - CW'(1);
         lap_bank = lap_bank_sub(lptr_ff, 3'd1);
      end else begin
         lrow     = irow_ff - RW'(2);
         lcol     = CW'(w_ext - (CW + 1)'(1));
         lap_bank = lap_bank_sub(lptr_ff, 3'd2);
      end
   end

   // result position trails the input by three rows and three pixels
   always_comb begin
      ostart = (irow_ff >= RW'(4)) || (irow_ff == RW'(3) && icol_ff >= CW'(3));
      if (icol_ff >= CW'(3)) begin
         orow     = irow_ff - RW'(3);
         ocol_ext = icol_ext - (CW + 1)'(3);
      end else begin
         orow     = irow_ff - RW'(4);
         ocol_ext = icol_ext + w_ext - (CW + 1)'(3);
      end
      ocol    = ocol_ext[CW-1:0];
      orow_p2 = {1'b0, orow} + (RW + 1)'(2);
   end

   // flags that ride with the request
   always_comb begin
      flags.lap_wr   = lstart && (lrow < h_ext);
      flags.lap_zero = (lrow == '0) || (lcol == '0) || (lrow >= h_ext - RW'(1)) ||
                       ({1'b0, lcol} >= w_ext - (CW + 1)'(1));
      flags.out_en   = ostart;
      flags.inner    = (orow >= RW'(2)) && (ocol >= CW'(2)) && (orow_p2 < {1'b0, h_ext}) &&
                       (({1'b0, ocol} + (CW + 1)'(2)) < w_ext);
      flags.last     = ostart && (orow == h_ext - RW'(1)) &&
                       ({1'b0, ocol} == w_ext - (CW + 1)'(1));
   end

   // advance the raster counters and ring pointers
   always_comb begin
      icol_in = icol_ff;
      irow_in = irow_ff;
      gptr_in = gptr_ff;
      lptr_in = lptr_ff;
      if (restart || (proc && flags.last)) begin
         icol_in = '0;
         irow_in = '0;
         gptr_in = '0;
         lptr_in = '0;
      end else if (proc) begin
         if (col_last) begin
            icol_in = '0;
            irow_in = irow_ff + RW'(1);
            gptr_in = gray_bank_add(gptr_ff, 2'd1);
            lptr_in = (lptr_ff == 3'(LAP_BANKS - 1)) ? 3'd0 : lptr_ff + 3'd1;
         end else begin
            icol_in = icol_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icol_ff <= '0;
         irow_ff <= '0;
         gptr_ff <= '0;
         lptr_ff <= '0;
      end else begin
         icol_ff <= icol_in;
         irow_ff <= irow_in;
         gptr_ff <= gptr_in;
         lptr_ff <= lptr_in;
      end
   end

   assign gray_new = gray_of(req_red, req_green, req_blue);

   // gray line buffers, one bank per row of the three-row ring
   for (genvar g = 0; g < GRAY_BANKS; g++) begin : g_gray
      lzc_ram #(
         .DEPTH (MAX_WIDTH),
         .WIDTH (8)
      ) u_ram (
         .clock   (clock),
         .wr_en   (gray_wr && (gptr_ff == 2'(g))),
         .wr_addr (icol_ff),
         .wr_data (gray_new),
         .rd_en   (proc),
         .rd_addr (icol_ff),
         .rd_data (gray_rd[g])
      );
   end

   // color line buffer, four rows deep
   lzc_ram #(
      .DEPTH (COLOR_BANKS * (1 << CW)),
      .WIDTH (24)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (gray_wr),
      .wr_addr ({irow_ff[CBW-1:0], icol_ff}),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_en   (proc),
      .rd_addr ({orow[CBW-1:0], ocol}),
      .rd_data (color_rd)
   );

   // input stage register
   assign a_valid_in = proc ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         a_flags_ff    <= flags;
         a_lap_bank_ff <= lap_bank;
         a_lap_col_ff  <= lcol;
         a_gray_ff     <= gray_new;
         a_gptr_ff     <= gptr_ff;
      end
   end

   assign a_valid    = a_valid_ff;
   assign a_flags    = a_flags_ff;
   assign a_lap_bank = a_lap_bank_ff;
   assign a_lap_col  = a_lap_col_ff;
   assign lap_rd_en  = proc;
   assign lap_rd_col = lcol;

   // gray column: two rows above, then the current row
   assign gray_col[0] = gray_rd[gray_bank_add(a_gptr_ff, 2'd1)];
   assign gray_col[1] = gray_rd[gray_bank_add(a_gptr_ff, 2'd2)];
   assign gray_col[2] = a_gray_ff;

endmodule

// ===== design/lzc_lap.sv =====
// ----------------------------------------------------------------------------
// lzc_lap
// 3x3 gray window, biased and clamped Laplacian, Laplacian line buffers,
// and the middle stage register.
// ----------------------------------------------------------------------------
module lzc_lap
   import lzc_pkg::*;
#(
   parameter int MAX_WIDTH = LZC_MAX_WIDTH,
   localparam int CW = $clog2(MAX_WIDTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       a_move,
   input  logic                       b_move,
   input  stage_flags_type            a_flags,
   input  logic [2:0]                 a_lap_bank,
   input  logic [CW-1:0]              a_lap_col,
   input  logic [GRAY_TAPS-1:0][7:0]  gray_col,
   input  logic [23:0]                color_in,
   input  logic                       lap_rd_en,
   input  logic [CW-1:0]              lap_rd_col,
   input  logic [7:0]                 bias,
   output logic                       b_valid,
   output stage_flags_type            b_flags,
   output logic [LAP_TAPS-1:0][7:0]   b_lap_col,
   output logic [23:0]                b_color
);

   logic [7:0] gw_ff [GRAY_TAPS][2];
   logic [7:0] lap_rd [LAP_BANKS];

   logic                     b_valid_ff, b_valid_in;
   stage_flags_type          b_flags_ff;
   logic [LAP_TAPS-1:0][7:0] b_lap_col_ff, b_lap_col_in;
   logic [23:0]              b_color_ff;

   logic [7:0]         center;
   logic [10:0]        nsum;
   logic signed [12:0] acc;
   logic [7:0]         lap_val;

   // shift the gray window one column per request
   always_ff @(posedge clock) begin
      if (a_move) begin
         for (int r = 0; r < GRAY_TAPS; r++) begin
            gw_ff[r][0] <= gw_ff[r][1];
            gw_ff[r][1] <= gray_col[r];
         end
      end
   end

   // 8*center minus eight neighbours, plus bias, clamped to a byte; zero on the outermost ring
   always_comb begin
      center = gw_ff[1][1];
      nsum   = 11'(gw_ff[0][0]) + 11'(gw_ff[0][1]) + 11'(gray_col[0]) +
               11'(gw_ff[1][0]) + 11'(gray_col[1]) +
               11'(gw_ff[2][0]) + 11'(gw_ff[2][1]) + 11'(gray_col[2]);
      acc    = $signed({2'b0, center, 3'b0}) - $signed({2'b0, nsum}) +
               $signed({5'b0, bias});
      if (a_flags.lap_zero || acc < 13'sd0) begin
         lap_val = 8'd0;
      end else if (acc > 13'sd255) begin
         lap_val = 8'd255;
      end else begin
         lap_val = acc[7:0];
      end
   end

   // Laplacian line buffers, five-row ring
   for (genvar k = 0; k < LAP_BANKS; k++) begin : g_lap
      lzc_ram #(
         .DEPTH (MAX_WIDTH),
         .WIDTH (8)
      ) u_ram (
         .clock   (clock),
         .wr_en   (a_move && a_flags.lap_wr && (a_lap_bank == 3'(k))),
         .wr_addr (a_lap_col),
         .wr_data (lap_val),
         .rd_en   (lap_rd_en),
         .rd_addr (lap_rd_col),
         .rd_data (lap_rd[k])
      );
   end

   // Laplacian column: four rows above from the ring, then the new value
   always_comb begin
      for (int k = 0; k < LAP_TAPS - 1; k++) begin
         b_lap_col_in[k] = lap_rd[lap_bank_sub(a_lap_bank, 3'(LAP_TAPS - 1 - k))];
      end
      b_lap_col_in[LAP_TAPS-1] = lap_val;
   end

   // middle stage register
   assign b_valid_in = a_move ? 1'b1 : (b_move ? 1'b0 : b_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_flags_ff   <= a_flags;
         b_lap_col_ff <= b_lap_col_in;
         b_color_ff   <= color_in;
      end
   end

   assign b_valid   = b_valid_ff;
   assign b_flags   = b_flags_ff;
   assign b_lap_col = b_lap_col_ff;
   assign b_color   = b_color_ff;

endmodule

// ===== design/lzc_edge.sv =====
// ----------------------------------------------------------------------------
// lzc_edge
// 5x5 Laplacian window, zero-crossing test, color overlay and the result
// register.
// ----------------------------------------------------------------------------
module lzc_edge
   import lzc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     b_move,
   input  logic                     c_load,
   input  logic                     c_take,
   input  stage_flags_type          b_flags,
   input  logic [LAP_TAPS-1:0][7:0] b_lap_col,
   input  logic [23:0]              b_color,
   input  logic [6:0]               threshold,
   input  logic [7:0]               bias,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_red,
   output logic [7:0]               rsp_out_green,
   output logic [7:0]               rsp_out_blue,
   output logic [7:0]               rsp_laplacian_level,
   output logic                     rsp_is_edge,
   output logic                     rsp_last
);

   logic [7:0] lw_ff [LAP_TAPS][LAP_TAPS-1];

   logic       c_valid_ff, c_valid_in;
   logic [7:0] out_red_ff, out_green_ff, out_blue_ff, level_ff;
   logic       is_edge_ff, last_ff;

   logic signed [9:0] lo, hi, v;
   logic              neg, pos, edge_hit;
   logic [7:0]        red_in, green_in, blue_in;

   // shift the Laplacian window one column per request
   always_ff @(posedge clock) begin
      if (b_move) begin
         for (int r = 0; r < LAP_TAPS; r++) begin
            for (int c = 0; c < LAP_TAPS - 2; c++) begin
               lw_ff[r][c] <= lw_ff[r][c+1];
            end
            lw_ff[r][LAP_TAPS-2] <= b_lap_col[r];
         end
      end
   end

   // look for strong responses of both signs in the window
   always_comb begin
      lo  = $signed({2'b0, bias}) - $signed({3'b0, threshold});
      hi  = $signed({2'b0, bias}) + $signed({3'b0, threshold});
      neg = 1'b0;
      pos = 1'b0;
      v   = '0;
      for (int r = 0; r < LAP_TAPS; r++) begin
         for (int c = 0; c < LAP_TAPS; c++) begin
            if (c == LAP_TAPS - 1) begin
               v = $signed({2'b0, b_lap_col[r]});
            end else begin
               v = $signed({2'b0, lw_ff[r][c]});
            end
            if (v < lo) begin
               neg = 1'b1;
            end
            if (v > hi) begin
               pos = 1'b1;
            end
         end
      end
      edge_hit = b_flags.inner && neg && pos;
   end

   // overlay: yellow on edges, black on the outer ring, else the pixel
   always_comb begin
      if (edge_hit) begin
         red_in   = 8'd255;
         green_in = 8'd255;
         blue_in  = 8'd0;
      end else if (b_flags.inner) begin
         red_in   = b_color[23:16];
         green_in = b_color[15:8];
         blue_in  = b_color[7:0];
      end else begin
         red_in   = 8'd0;
         green_in = 8'd0;
         blue_in  = 8'd0;
      end
   end

   // result register
   assign c_valid_in = c_load ? 1'b1 : (c_take ? 1'b0 : c_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         out_red_ff   <= red_in;
         out_green_ff <= green_in;
         out_blue_ff  <= blue_in;
         level_ff     <= lw_ff[2][2];
         is_edge_ff   <= edge_hit;
         last_ff      <= b_flags.last;
      end
   end

   assign rsp_valid           = c_valid_ff;
   assign rsp_out_red         = out_red_ff;
   assign rsp_out_green       = out_green_ff;
   assign rsp_out_blue        = out_blue_ff;
   assign rsp_laplacian_level = level_ff;
   assign rsp_is_edge         = is_edge_ff;
   assign rsp_last            = last_ff;

endmodule

// ===== design/laplacian_zero_crossing_edge_overlay.sv =====
// ----------------------------------------------------------------------------
// laplacian_zero_crossing_edge_overlay
// Streaming RGB edge overlay using zero crossings of a 3x3 Laplacian.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one request per clock when neither side
// stalls; each request is held first in the input register and then in the
// Laplacian stage register before it loads the result register. A result
// is presented once the request that completes it has been accepted and
// has passed both stage registers. Results lag the stream by
// 3*width+3 requests: after the last pixel of a frame, send that many flush
// ticks (mode 1) to drain the tail; a flush before all pixels are in is
// dropped. Edge pixels come out yellow, the outer two rows and columns black.
// Line buffers of MAX_WIDTH entries hold three gray rows, five Laplacian rows
// and four color rows; their contents need no clearing after reset. Writing
// frame_width or frame_height restarts the frame; width and height are used
// clamped to 5..MAX. Configure only while the block is idle.
// ----------------------------------------------------------------------------
module laplacian_zero_crossing_edge_overlay
   import lzc_pkg::*;
#(
   parameter int MAX_WIDTH  = LZC_MAX_WIDTH,
   parameter int MAX_HEIGHT = LZC_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue,
   output logic [7:0]             rsp_laplacian_level,
   output logic                   rsp_is_edge,
   output logic                   rsp_last,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [11:0] frame_width_ff, frame_height_ff;
   logic [6:0]  edge_threshold_ff;
   logic [7:0]  laplacian_bias_ff;
   logic        csr_write, restart;
   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;

   logic                     req_take;
   logic                     a_valid, a_move;
   stage_flags_type          a_flags;
   logic [2:0]               a_lap_bank;
   logic [CW-1:0]            a_lap_col;
   logic [GRAY_TAPS-1:0][7:0] gray_col;
   logic [23:0]              color_rd;
   logic                     lap_rd_en;
   logic [CW-1:0]            lap_rd_col;
   logic                     b_valid, b_move;
   stage_flags_type          b_flags;
   logic [LAP_TAPS-1:0][7:0] b_lap_col;
   logic [23:0]              b_color;
   logic                     c_load, c_take, c_free;

   // configuration registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RST;
         frame_height_ff   <= FRAME_HEIGHT_RST;
         edge_threshold_ff <= EDGE_THRESHOLD_RST;
         laplacian_bias_ff <= LAPLACIAN_BIAS_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_data[11:0];
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_data[11:0];
            CSR_EDGE_THRESHOLD: edge_threshold_ff <= csr_data[6:0];
            CSR_LAPLACIAN_BIAS: laplacian_bias_ff <= csr_data[7:0];
         endcase
      end
   end

   // a new frame size restarts the raster
   assign restart = csr_write && ((csr_index_type'(csr_index) == CSR_FRAME_WIDTH) ||
                                  (csr_index_type'(csr_index) == CSR_FRAME_HEIGHT));

   // clamp the frame size to the supported range
   always_comb begin
      if (frame_width_ff < 12'(MIN_SIZE)) begin
         eff_w = WW'(MIN_SIZE);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(frame_width_ff);
      end
      if (frame_height_ff < 12'(MIN_SIZE)) begin
         eff_h = HW'(MIN_SIZE);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(frame_height_ff);
      end
   end

   // pipeline flow: a stage moves when the next one is empty or moving
   assign c_take    = rsp_valid && !rsp_stall;
   assign c_free    = !rsp_valid || !rsp_stall;
   assign b_move    = b_valid && (!b_flags.out_en || c_free);
   assign c_load    = b_move && b_flags.out_en;
   assign a_move    = a_valid && (!b_valid || b_move);
   assign req_stall = a_valid && !a_move;
   assign req_take  = req_valid && !req_stall;

   lzc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .req_take   (req_take),
      .req_mode   (req_mode),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .a_move     (a_move),
      .a_valid    (a_valid),
      .a_flags    (a_flags),
      .a_lap_bank (a_lap_bank),
      .a_lap_col  (a_lap_col),
      .gray_col   (gray_col),
      .color_rd   (color_rd),
      .lap_rd_en  (lap_rd_en),
      .lap_rd_col (lap_rd_col)
   );

   lzc_lap #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_lap (
      .clock      (clock),
      .reset      (reset),
      .a_move     (a_move),
      .b_move     (b_move),
      .a_flags    (a_flags),
      .a_lap_bank (a_lap_bank),
      .a_lap_col  (a_lap_col),
      .gray_col   (gray_col),
      .color_in   (color_rd),
      .lap_rd_en  (lap_rd_en),
      .lap_rd_col (lap_rd_col),
      .bias       (laplacian_bias_ff),
      .b_valid    (b_valid),
      .b_flags    (b_flags),
      .b_lap_col  (b_lap_col),
      .b_color    (b_color)
   );

   lzc_edge u_edge (
      .clock               (clock),
      .reset               (reset),
      .b_move              (b_move),
      .c_load              (c_load),
      .c_take              (c_take),
      .b_flags             (b_flags),
      .b_lap_col           (b_lap_col),
      .b_color             (b_color),
      .threshold           (edge_threshold_ff),
      .bias                (laplacian_bias_ff),
      .rsp_valid           (rsp_valid),
      .rsp_out_red         (rsp_out_red),
      .rsp_out_green       (rsp_out_green),
      .rsp_out_blue        (rsp_out_blue),
      .rsp_laplacian_level (rsp_laplacian_level),
      .rsp_is_edge         (rsp_is_edge),
      .rsp_last            (rsp_last)
   );

endmodule
